### hdl/lcfb_pkg.sv
// shared types, codes and helpers for the led controller frame builder
package lcfb_pkg;

   // command codes
   localparam logic [2:0] FUNC_ON    = 3'd0;
   localparam logic [2:0] FUNC_OFF   = 3'd1;
   localparam logic [2:0] FUNC_WHITE = 3'd2;
   localparam logic [2:0] FUNC_COLOR = 3'd3;
   localparam logic [2:0] FUNC_LEVEL = 3'd4;

   // colour mode codes
   localparam logic [1:0] MODE_WHITE  = 2'd0;
   localparam logic [1:0] MODE_RGB    = 2'd1;
   localparam logic [1:0] MODE_CUSTOM = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_FRAME    = 2'd0;
   localparam logic [1:0] STATUS_BAD_CMD  = 2'd1;
   localparam logic [1:0] STATUS_BAD_MODE = 2'd2;

   // internal frame kinds between the scaling and assembly stages
   localparam logic [2:0] KIND_ON       = 3'd0;
   localparam logic [2:0] KIND_OFF      = 3'd1;
   localparam logic [2:0] KIND_COLOR    = 3'd2;
   localparam logic [2:0] KIND_BAD_CMD  = 3'd3;
   localparam logic [2:0] KIND_BAD_MODE = 3'd4;

   // frame bytes
   localparam logic [7:0] HDR_SWITCH = 8'h71;
   localparam logic [7:0] CODE_ON    = 8'h23;
   localparam logic [7:0] CODE_OFF   = 8'h24;
   localparam logic [7:0] HDR_COLOR  = 8'h31;
   localparam logic [7:0] TAIL_A     = 8'hF0;
   localparam logic [7:0] TAIL_B     = 8'h0F;
   localparam logic [7:0] FULL       = 8'hFF;

   localparam logic [6:0] PERCENT = 7'd100;

   // floor(p / 100) for p up to 255 * 100, exact over that range
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // highest byte index of a switch frame and of a colour frame
   localparam logic [2:0] LAST_SWITCH = 3'd2;
   localparam logic [2:0] LAST_COLOR  = 3'd6;

   typedef struct packed {
      logic [2:0] func;
      logic [1:0] color_mode;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] warm_in;
      logic [6:0] level;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic [1:0] status;
   } rsp_type;

   // one assembled frame, checksum excluded; entry 7 stays zero
   typedef struct packed {
      logic [7:0][7:0] data;
      logic [2:0]      last_idx;
      logic            is_status;
      logic [1:0]      status;
   } frame_type;

   function automatic logic [7:0] div100(input logic [14:0] p);
      logic [27:0] m;
      m = 28'(p) * 28'(RECIP_100);
      return m[RECIP_SHIFT+7:RECIP_SHIFT];
   endfunction

endpackage

### hdl/led_controller_frame_builder.sv
// top level of the led controller frame builder
// Each accepted command turns into one byte frame for an RGBW LED controller,
// sent one byte per rsp beat with last_byte set on the closing checksum beat;
// an unhandled command or colour mode gives a single status beat instead.
// A command passes an input register, a scaling stage (held colour update and
// channel times level products) and an assembly stage (divide by 100 through a
// reciprocal multiply) before the serializer, whose output register presents
// each byte on rsp. Throughput is set by the serializer's single output byte per
// cycle while rsp_stall is low: an on/off frame is 4 bytes with checksum, a colour
// frame 8 and a status beat 1; commands are accepted every cycle while the stages
// have room.
module led_controller_frame_builder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcfb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcfb_pkg::rsp_type rsp_data
);

   // input register
   logic              req_vld_ff, req_vld_in;
   lcfb_pkg::req_type req_ff;

   // held colour: [3] red, [2] green, [1] blue, [0] warm
   logic [3:0][7:0]   held_ff, held_in;

   // scaling stage
   logic              s1_vld_ff, s1_vld_in;
   logic [2:0]        kind_ff, kind_in;
   logic [3:0][14:0]  prod_ff, prod_in;
   logic [6:0]        scale_lvl;

   // assembly stage
   logic                frm_vld_ff, frm_vld_in;
   lcfb_pkg::frame_type frm_ff, frm_in;
   logic                frm_take;

   logic req_adv, s1_adv, req_go;

   // stage advance chain
   assign s1_adv    = !frm_vld_ff || frm_take;
   assign req_adv   = !s1_vld_ff || s1_adv;
   assign req_stall = req_vld_ff && !req_adv;
   assign req_go    = req_vld_ff && req_adv;

   assign req_vld_in = (req_valid && !req_stall) || (req_vld_ff && !req_adv);
   assign s1_vld_in  = req_adv ? req_vld_ff : s1_vld_ff;
   assign frm_vld_in = s1_adv ? s1_vld_ff : frm_vld_ff;

   // command decode and held colour update
   always_comb begin
      held_in   = held_ff;
      kind_in   = lcfb_pkg::KIND_BAD_CMD;
      scale_lvl = (req_ff.level > lcfb_pkg::PERCENT) ? lcfb_pkg::PERCENT : req_ff.level;
      unique case (req_ff.func)
         lcfb_pkg::FUNC_ON: begin
            kind_in = lcfb_pkg::KIND_ON;
         end
         lcfb_pkg::FUNC_OFF: begin
            kind_in = lcfb_pkg::KIND_OFF;
         end
         lcfb_pkg::FUNC_WHITE: begin
            held_in   = {4{lcfb_pkg::FULL}};
            scale_lvl = lcfb_pkg::PERCENT;
            kind_in   = lcfb_pkg::KIND_COLOR;
         end
         lcfb_pkg::FUNC_COLOR: begin
            kind_in = lcfb_pkg::KIND_COLOR;
            unique case (req_ff.color_mode)
               lcfb_pkg::MODE_WHITE: begin
                  held_in = {4{lcfb_pkg::FULL}};
               end
               lcfb_pkg::MODE_RGB: begin
                  held_in[3] = req_ff.red_in;
                  held_in[2] = req_ff.green_in;
                  held_in[1] = req_ff.blue_in;
                  held_in[0] = 8'd0;
               end
               lcfb_pkg::MODE_CUSTOM: begin
                  held_in[3] = req_ff.red_in;
                  held_in[2] = req_ff.green_in;
                  held_in[1] = req_ff.blue_in;
                  held_in[0] = req_ff.warm_in;
               end
               lcfb_pkg::MODE_NONE: begin
                  kind_in = lcfb_pkg::KIND_BAD_MODE;
               end
            endcase
         end
         lcfb_pkg::FUNC_LEVEL: begin
            kind_in = lcfb_pkg::KIND_COLOR;
         end
         default: begin
            kind_in = lcfb_pkg::KIND_BAD_CMD;
         end
      endcase
   end

   // channel times level products
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = 15'(held_in[i]) * 15'(scale_lvl);
      end
   end

   // frame assembly
   always_comb begin
      frm_in           = '0;
      frm_in.status    = lcfb_pkg::STATUS_FRAME;
      unique case (kind_ff)
         lcfb_pkg::KIND_ON, lcfb_pkg::KIND_OFF: begin
            frm_in.data[0]  = lcfb_pkg::HDR_SWITCH;
            frm_in.data[1]  = (kind_ff == lcfb_pkg::KIND_ON) ?
                              lcfb_pkg::CODE_ON : lcfb_pkg::CODE_OFF;
            frm_in.data[2]  = lcfb_pkg::TAIL_B;
            frm_in.last_idx = lcfb_pkg::LAST_SWITCH;
         end
         lcfb_pkg::KIND_COLOR: begin
            frm_in.data[0]  = lcfb_pkg::HDR_COLOR;
            frm_in.data[1]  = lcfb_pkg::div100(prod_ff[3]);
            frm_in.data[2]  = lcfb_pkg::div100(prod_ff[2]);
            frm_in.data[3]  = lcfb_pkg::div100(prod_ff[1]);
            frm_in.data[4]  = lcfb_pkg::div100(prod_ff[0]);
            frm_in.data[5]  = lcfb_pkg::TAIL_A;
            frm_in.data[6]  = lcfb_pkg::TAIL_B;
            frm_in.last_idx = lcfb_pkg::LAST_COLOR;
         end
         lcfb_pkg::KIND_BAD_MODE: begin
            frm_in.is_status = 1'b1;
            frm_in.status    = lcfb_pkg::STATUS_BAD_MODE;
         end
         default: begin
            frm_in.is_status = 1'b1;
            frm_in.status    = lcfb_pkg::STATUS_BAD_CMD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         frm_vld_ff <= 1'b0;
         held_ff    <= {4{lcfb_pkg::FULL}};
      end else begin
         req_vld_ff <= req_vld_in;
         s1_vld_ff  <= s1_vld_in;
         frm_vld_ff <= frm_vld_in;
         if (req_go) begin
            held_ff <= held_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (req_go) begin
         kind_ff <= kind_in;
         prod_ff <= prod_in;
      end
      if (s1_adv && s1_vld_ff) begin
         frm_ff <= frm_in;
      end
   end

   lcfb_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .frm       (frm_ff),
      .frm_vld   (frm_vld_ff),
      .frm_take  (frm_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // status beats always close their run with a zero byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != lcfb_pkg::STATUS_FRAME) |->
      (rsp_data.last_byte && rsp_data.frame_byte == 8'd0))
      else $error("status beat without last_byte or with nonzero byte");

   // the serializer only releases a frame it holds
   assert property (@(posedge clock) disable iff (reset)
      frm_take |-> frm_vld_ff)
      else $error("frame released while none is held");

   // held colour moves only when a command leaves the input register
   assert property (@(posedge clock) disable iff (reset)
      !req_go |=> $stable(held_ff))
      else $error("held colour changed without a command");

   // a frame waiting in the assembly register is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (frm_vld_ff && !frm_take) |=> (frm_vld_ff && $stable(frm_ff)))
      else $error("pending frame overwritten");
`endif

endmodule

### hdl/lcfb_tx.sv
// frame serializer: sends one frame byte per beat and appends the checksum
module lcfb_tx (
   input  logic                clock,
   input  logic                reset,
   input  lcfb_pkg::frame_type frm,
   input  logic                frm_vld,
   output logic                frm_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lcfb_pkg::rsp_type   rsp_data
);

   logic [2:0]        idx_ff, idx_in;
   logic [7:0]        sum_ff, sum_in;
   logic              rsp_vld_ff, rsp_vld_in;
   lcfb_pkg::rsp_type rsp_ff, rsp_in;
   logic              out_load;

   assign out_load = !rsp_vld_ff || !rsp_stall;

   // pick the next beat out of the held frame
   always_comb begin
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      frm_take   = 1'b0;
      if (out_load) begin
         rsp_vld_in = frm_vld;
         if (frm_vld) begin
            priority if (frm.is_status) begin
               rsp_in.frame_byte = 8'd0;
               rsp_in.last_byte  = 1'b1;
               rsp_in.status     = frm.status;
               frm_take          = 1'b1;
            end else if (idx_ff <= frm.last_idx) begin
               rsp_in.frame_byte = frm.data[idx_ff];
               rsp_in.last_byte  = 1'b0;
               rsp_in.status     = lcfb_pkg::STATUS_FRAME;
               sum_in            = sum_ff + frm.data[idx_ff];
               idx_in            = idx_ff + 3'd1;
            end else begin
               rsp_in.frame_byte = sum_ff;
               rsp_in.last_byte  = 1'b1;
               rsp_in.status     = lcfb_pkg::STATUS_FRAME;
               sum_in            = 8'd0;
               idx_in            = 3'd0;
               frm_take          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 3'd0;
         sum_ff     <= 8'd0;
         rsp_vld_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         sum_ff     <= sum_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
